@@ sv/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue: sizes, command
// and status codes, the stored entry layout and the sequencer states.
// ----------------------------------------------------------------------------
package spq_pkg;

   // queue geometry
   localparam int QUEUE_DEPTH = 16;
   localparam int ID_BITS     = 10;
   localparam int PRIO_BITS   = 8;
   localparam int CMD_BITS    = 2;
   localparam int STATUS_BITS = 2;
   localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   // request commands
   typedef enum logic [CMD_BITS-1:0] {
      CMD_PUSH   = 2'd0,
      CMD_POP    = 2'd1,
      CMD_SEARCH = 2'd2,
      CMD_NOP    = 2'd3
   } spq_cmd_type;

   // response status codes
   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } spq_status_type;

   // one stored queue entry
   typedef struct packed {
      logic [PRIO_BITS-1:0] prio;
      logic [ID_BITS-1:0]   id;
   } spq_entry_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUSH_CMP,
      ST_PUSH_WR,
      ST_POP_MOV,
      ST_SEARCH,
      ST_HEAD,
      ST_RESULT
   } spq_state_type;

endpackage

@@ sv/spq_req_if.sv @@
// ----------------------------------------------------------------------------
// spq_req_if
// Request channel of the sorted priority queue: valid/ready plus command,
// pushed priority and searched id.
// ----------------------------------------------------------------------------
interface spq_req_if;

   logic                          valid;
   logic                          ready;
   logic [spq_pkg::CMD_BITS-1:0]  cmd;
   logic [spq_pkg::PRIO_BITS-1:0] priority_req;
   logic [spq_pkg::ID_BITS-1:0]   query_id;

   modport source (
      output valid, cmd, priority_req, query_id,
      input  ready
   );

   modport sink (
      input  valid, cmd, priority_req, query_id,
      output ready
   );

endinterface

@@ sv/spq_rsp_if.sv @@
// ----------------------------------------------------------------------------
// spq_rsp_if
// Response channel of the sorted priority queue: valid/ready plus status,
// assigned id, search flag, head entry and occupancy.
// ----------------------------------------------------------------------------
interface spq_rsp_if;

   logic                            valid;
   logic                            ready;
   logic [spq_pkg::STATUS_BITS-1:0] status;
   logic [spq_pkg::ID_BITS-1:0]     new_id;
   logic                            found;
   logic                            head_valid;
   logic [spq_pkg::ID_BITS-1:0]     head_id;
   logic [spq_pkg::PRIO_BITS-1:0]   head_priority;
   logic [spq_pkg::COUNT_BITS-1:0]  occupancy;

   modport source (
      output valid, status, new_id, found, head_valid, head_id, head_priority,
             occupancy,
      input  ready
   );

   modport sink (
      input  valid, status, new_id, found, head_valid, head_id, head_priority,
             occupancy,
      output ready
   );

endinterface

@@ sv/sorted_priority_queue.sv @@
// Steps: push moves larger entries back one at a time, pop shifts the rest toward the
//    head, search scans from the head, refused or no-op requests go to the head fetch.
// Throughput: one request at a time; the next is taken the cycle after the
//    result is registered, while that result may still wait for rsp ready.
// The pace is set by the slot RAM, one entry read and one written a cycle.
// Reset: synchronous, empties the queue and zeroes the id counter; slots are not cleared.
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept sorted by ascending priority code, stable for
// equal codes. A small sequencer walks the slot RAM to insert, shift out the
// head or search for an id.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
   input  logic       clock,
   input  logic       reset,
   spq_req_if.sink    req_ch,
   spq_rsp_if.source  rsp_ch
);

   // sequencer and control registers
   spq_pkg::spq_state_type            state_ff, state_in;
   logic [spq_pkg::COUNT_BITS-1:0]    count_ff, count_in;
   logic [spq_pkg::ID_BITS-1:0]       id_ctr_ff, id_ctr_in;
   logic [spq_pkg::IDX_BITS-1:0]      pos_ff, pos_in;

   // latched request
   logic [spq_pkg::PRIO_BITS-1:0]     prio_ff, prio_in;
   logic [spq_pkg::ID_BITS-1:0]       qid_ff, qid_in;

   // per-request results
   spq_pkg::spq_status_type           status_ff, status_in;
   logic [spq_pkg::ID_BITS-1:0]       new_id_ff, new_id_in;
   logic                              found_ff, found_in;

   // response register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [spq_pkg::STATUS_BITS-1:0]   rsp_status_ff, rsp_status_in;
   logic [spq_pkg::ID_BITS-1:0]       rsp_new_id_ff, rsp_new_id_in;
   logic                              rsp_found_ff, rsp_found_in;
   logic                              rsp_head_valid_ff, rsp_head_valid_in;
   logic [spq_pkg::ID_BITS-1:0]       rsp_head_id_ff, rsp_head_id_in;
   logic [spq_pkg::PRIO_BITS-1:0]     rsp_head_prio_ff, rsp_head_prio_in;
   logic [spq_pkg::COUNT_BITS-1:0]    rsp_occ_ff, rsp_occ_in;

   // slot RAM
   spq_pkg::spq_entry_type            slot_ff [spq_pkg::QUEUE_DEPTH];
   spq_pkg::spq_entry_type            rd_data_ff;
   logic [spq_pkg::IDX_BITS-1:0]      rd_addr;
   logic                              wr_en;
   logic [spq_pkg::IDX_BITS-1:0]      wr_addr;
   spq_pkg::spq_entry_type            wr_data;

   // shared compare helpers
   logic                              req_fire;
   logic                              rsp_free;
   logic                              queue_full;
   logic                              moves_back;
   logic                              id_match;
   logic                              more_left;
   logic [spq_pkg::COUNT_BITS-1:0]    pos_next_ext;
   spq_pkg::spq_entry_type            new_entry;

   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign queue_full   = (count_ff == spq_pkg::COUNT_BITS'(spq_pkg::QUEUE_DEPTH));
   assign moves_back   = (rd_data_ff.prio > prio_ff);
   assign id_match     = (rd_data_ff.id == qid_ff);
   assign pos_next_ext = {1'b0, pos_ff} + spq_pkg::COUNT_BITS'(1);
   assign more_left    = (pos_next_ext < count_ff);
   assign new_entry    = '{prio: prio_ff, id: id_ctr_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         spq_pkg::ST_IDLE: begin
            if (req_fire) begin
               unique case (req_ch.cmd)
                  spq_pkg::CMD_PUSH: begin
                     if (queue_full) begin
                        state_in = spq_pkg::ST_HEAD;
                     end else if (count_ff == '0) begin
                        state_in = spq_pkg::ST_PUSH_WR;
                     end else begin
                        state_in = spq_pkg::ST_PUSH_CMP;
                     end
                  end
                  spq_pkg::CMD_POP: begin
                     if (count_ff <= spq_pkg::COUNT_BITS'(1)) begin
                        state_in = spq_pkg::ST_HEAD;
                     end else begin
                        state_in = spq_pkg::ST_POP_MOV;
                     end
                  end
                  spq_pkg::CMD_SEARCH: begin
                     if (count_ff == '0) begin
                        state_in = spq_pkg::ST_HEAD;
                     end else begin
                        state_in = spq_pkg::ST_SEARCH;
                     end
                  end
                  default: begin
                     state_in = spq_pkg::ST_HEAD;
                  end
               endcase
            end
         end
         spq_pkg::ST_PUSH_CMP: begin
            if (!moves_back) begin
               state_in = spq_pkg::ST_HEAD;
            end else if (pos_ff == spq_pkg::IDX_BITS'(1)) begin
               state_in = spq_pkg::ST_PUSH_WR;
            end
         end
         spq_pkg::ST_PUSH_WR: begin
            state_in = spq_pkg::ST_HEAD;
         end
         spq_pkg::ST_POP_MOV: begin
            if (!more_left) begin
               state_in = spq_pkg::ST_HEAD;
            end
         end
         spq_pkg::ST_SEARCH: begin
            if (id_match || !more_left) begin
               state_in = spq_pkg::ST_HEAD;
            end
         end
         spq_pkg::ST_HEAD: begin
            state_in = spq_pkg::ST_RESULT;
         end
         spq_pkg::ST_RESULT: begin
            if (rsp_free) begin
               state_in = spq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = spq_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath, ram control and outputs
   always_comb begin
      count_in          = count_ff;
      id_ctr_in         = id_ctr_ff;
      pos_in            = pos_ff;
      prio_in           = prio_ff;
      qid_in            = qid_ff;
      status_in         = status_ff;
      new_id_in         = new_id_ff;
      found_in          = found_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in     = rsp_status_ff;
      rsp_new_id_in     = rsp_new_id_ff;
      rsp_found_in      = rsp_found_ff;
      rsp_head_valid_in = rsp_head_valid_ff;
      rsp_head_id_in    = rsp_head_id_ff;
      rsp_head_prio_in  = rsp_head_prio_ff;
      rsp_occ_in        = rsp_occ_ff;
      rd_addr           = '0;
      wr_en             = 1'b0;
      wr_addr           = pos_ff;
      wr_data           = new_entry;
      req_ch.ready      = 1'b0;

      unique case (state_ff)
         // take a request and issue the first slot read
         spq_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_fire) begin
               prio_in   = req_ch.priority_req;
               qid_in    = req_ch.query_id;
               status_in = spq_pkg::STATUS_DONE;
               new_id_in = '0;
               found_in  = 1'b0;
               unique case (req_ch.cmd)
                  spq_pkg::CMD_PUSH: begin
                     pos_in  = count_ff[spq_pkg::IDX_BITS-1:0];
                     rd_addr = count_ff[spq_pkg::IDX_BITS-1:0] - spq_pkg::IDX_BITS'(1);
                     if (queue_full) begin
                        status_in = spq_pkg::STATUS_FULL;
                     end
                  end
                  spq_pkg::CMD_POP: begin
                     pos_in  = spq_pkg::IDX_BITS'(1);
                     rd_addr = spq_pkg::IDX_BITS'(1);
                     if (count_ff == '0) begin
                        status_in = spq_pkg::STATUS_EMPTY;
                     end else if (count_ff == spq_pkg::COUNT_BITS'(1)) begin
                        count_in = '0;
                     end
                  end
                  spq_pkg::CMD_SEARCH: begin
                     pos_in  = '0;
                     rd_addr = '0;
                  end
                  default: begin
                     pos_in = '0;
                  end
               endcase
            end
         end
         // move larger codes back one slot, or drop the new entry in
         spq_pkg::ST_PUSH_CMP: begin
            wr_en = 1'b1;
            if (moves_back) begin
               wr_data = rd_data_ff;
               pos_in  = pos_ff - spq_pkg::IDX_BITS'(1);
               rd_addr = pos_ff - spq_pkg::IDX_BITS'(2);
            end else begin
               count_in  = count_ff + spq_pkg::COUNT_BITS'(1);
               id_ctr_in = id_ctr_ff + spq_pkg::ID_BITS'(1);
               new_id_in = id_ctr_ff;
            end
         end
         // new entry lands at the head or into an empty queue
         spq_pkg::ST_PUSH_WR: begin
            wr_en     = 1'b1;
            count_in  = count_ff + spq_pkg::COUNT_BITS'(1);
            id_ctr_in = id_ctr_ff + spq_pkg::ID_BITS'(1);
            new_id_in = id_ctr_ff;
         end
         // shift entries one slot toward the head
         spq_pkg::ST_POP_MOV: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff - spq_pkg::IDX_BITS'(1);
            wr_data = rd_data_ff;
            if (more_left) begin
               pos_in  = pos_ff + spq_pkg::IDX_BITS'(1);
               rd_addr = pos_ff + spq_pkg::IDX_BITS'(1);
            end else begin
               count_in = count_ff - spq_pkg::COUNT_BITS'(1);
            end
         end
         // linear id search from the head
         spq_pkg::ST_SEARCH: begin
            if (id_match) begin
               found_in = 1'b1;
            end else if (more_left) begin
               pos_in  = pos_ff + spq_pkg::IDX_BITS'(1);
               rd_addr = pos_ff + spq_pkg::IDX_BITS'(1);
            end
         end
         // fetch the head slot
         spq_pkg::ST_HEAD: begin
            rd_addr = '0;
         end
         // load the response register once it is free
         spq_pkg::ST_RESULT: begin
            if (rsp_free) begin
               rsp_valid_in      = 1'b1;
               rsp_status_in     = status_ff;
               rsp_new_id_in     = new_id_ff;
               rsp_found_in      = found_ff;
               rsp_head_valid_in = (count_ff != '0);
               rsp_head_id_in    = (count_ff != '0) ? rd_data_ff.id : '0;
               rsp_head_prio_in  = (count_ff != '0) ? rd_data_ff.prio : '0;
               rsp_occ_in        = count_ff;
            end
         end
         default: begin
            rd_addr = '0;
         end
      endcase
   end

   // slot ram, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_ff[rd_addr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spq_pkg::ST_IDLE;
         count_ff     <= '0;
         id_ctr_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         id_ctr_ff    <= id_ctr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pos_ff            <= pos_in;
      prio_ff           <= prio_in;
      qid_ff            <= qid_in;
      status_ff         <= status_in;
      new_id_ff         <= new_id_in;
      found_ff          <= found_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_new_id_ff     <= rsp_new_id_in;
      rsp_found_ff      <= rsp_found_in;
      rsp_head_valid_ff <= rsp_head_valid_in;
      rsp_head_id_ff    <= rsp_head_id_in;
      rsp_head_prio_ff  <= rsp_head_prio_in;
      rsp_occ_ff        <= rsp_occ_in;
   end

   // response port
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.new_id        = rsp_new_id_ff;
   assign rsp_ch.found         = rsp_found_ff;
   assign rsp_ch.head_valid    = rsp_head_valid_ff;
   assign rsp_ch.head_id       = rsp_head_id_ff;
   assign rsp_ch.head_priority = rsp_head_prio_ff;
   assign rsp_ch.occupancy     = rsp_occ_ff;

   // occupancy never passes the queue depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= spq_pkg::COUNT_BITS'(spq_pkg::QUEUE_DEPTH))
      else $error("queue count above depth");

   // an accepted request leaves the idle state
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != spq_pkg::ST_IDLE)
      else $error("sequencer stayed idle after a request");

   // a refused push reports a full queue
   a_full_refusal: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == spq_pkg::STATUS_FULL)
         |-> rsp_occ_ff == spq_pkg::COUNT_BITS'(spq_pkg::QUEUE_DEPTH))
      else $error("push refused while queue not full");

   // head valid agrees with occupancy
   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_head_valid_ff == (rsp_occ_ff != '0))
      else $error("head valid disagrees with occupancy");

endmodule
